/* rtl/core/emb3_pkg.sv */
package emb3_pkg;

  localparam int MaxWidth   = 2048;
  localparam int AddrW      = $clog2(MaxWidth);
  localparam int ColW       = 11;
  localparam int RowW       = 16;
  localparam int PixW       = 8;
  localparam int WidthRegW  = 12;
  localparam int HeightRegW = 16;
  localparam int ScaleW     = 15;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam int SumW       = 11;
  localparam int ProdW      = SumW + ScaleW;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_Q15    = 2'd2;

  localparam logic [WidthRegW-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HeightRegW-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [ScaleW-1:0]     SCALE_RESET  = 15'd5461;
  localparam logic [SumW-1:0]       SUM_OFFSET   = 11'd765;
  localparam logic [ProdW:0]        ROUND_HALF   = 27'd16384;
  localparam int                    FracBits     = 15;

  typedef struct packed {
    logic [PixW-1:0] pixel_in;
    logic            frame_start;
  } in_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_out;
    logic [RowW-1:0] out_row;
    logic [ColW-1:0] out_col;
  } out_t;

endpackage

/* rtl/core/emboss_3x3_stream_filter_core.sv */
// input beat to result beat: input register, then result register
// one pixel per cycle unless stalled; one line store read and one write per cycle
// a result beat waiting on out_ready holds the input side only when the next pixel
// also yields a result
// reset clears counters, window, valid flags and registers to defaults; line stores
// are not cleared
module emboss_3x3_stream_filter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  emb3_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output emb3_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [emb3_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [emb3_pkg::CfgDataW-1:0]       cfg_data
);

  logic [emb3_pkg::WidthRegW-1:0]  image_width;
  logic [emb3_pkg::HeightRegW-1:0] image_height;
  logic [emb3_pkg::ScaleW-1:0]     scale_q15;

  logic [emb3_pkg::WidthRegW-1:0]  width_eff;
  logic [emb3_pkg::HeightRegW-1:0] height_eff;

  logic [emb3_pkg::RowW-1:0] row_count, row_count_next;
  logic [emb3_pkg::ColW-1:0] col_count, col_count_next;
  logic [emb3_pkg::RowW-1:0] row_cur;
  logic [emb3_pkg::ColW-1:0] col_cur;
  logic [emb3_pkg::RowW:0]   row_inc;
  logic [emb3_pkg::WidthRegW-1:0] col_inc;
  logic                      produce_cur;

  logic [2*emb3_pkg::PixW-1:0] line_mem [emb3_pkg::MaxWidth];
  logic [2*emb3_pkg::PixW-1:0] rdata;
  logic [2*emb3_pkg::PixW-1:0] wdata;

  logic                         s1_valid;
  logic                         s1_produce;
  logic [emb3_pkg::PixW-1:0]    s1_pixel;
  logic [emb3_pkg::AddrW-1:0]   s1_addr;
  logic [emb3_pkg::RowW-1:0]    s1_row;
  logic [emb3_pkg::ColW-1:0]    s1_col;
  logic                         s1_adv;
  logic                         accept;

  logic [emb3_pkg::PixW-1:0] w_top [3];
  logic [emb3_pkg::PixW-1:0] w_mid [3];
  logic [emb3_pkg::PixW-1:0] w_bot [3];

  logic [emb3_pkg::PixW-1:0] top_px, mid_px;
  logic [emb3_pkg::SumW-1:0] pos_sum, neg_sum, sum;
  logic [emb3_pkg::ProdW:0]  prod;
  logic [emb3_pkg::ProdW-emb3_pkg::FracBits:0] scaled;
  logic [emb3_pkg::PixW-1:0] sat_px;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= emb3_pkg::WIDTH_RESET;
      image_height <= emb3_pkg::HEIGHT_RESET;
      scale_q15    <= emb3_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        emb3_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[emb3_pkg::WidthRegW-1:0];
        emb3_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[emb3_pkg::HeightRegW-1:0];
        emb3_pkg::CFG_SCALE_Q15:    scale_q15    <= cfg_data[emb3_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff = image_width;
    if (image_width < emb3_pkg::WidthRegW'(3)) width_eff = emb3_pkg::WidthRegW'(3);
    if (image_width > emb3_pkg::WidthRegW'(emb3_pkg::MaxWidth)) begin
      width_eff = emb3_pkg::WidthRegW'(emb3_pkg::MaxWidth);
    end
    height_eff = image_height;
    if (image_height < emb3_pkg::HeightRegW'(3)) height_eff = emb3_pkg::HeightRegW'(3);
  end

  // position of the incoming beat
  assign accept = in_valid && in_ready;

  always_comb begin
    row_cur = in_data.frame_start ? '0 : row_count;
    col_cur = in_data.frame_start ? '0 : col_count;
    row_inc = {1'b0, row_cur} + 1'b1;
    col_inc = {1'b0, col_cur} + 1'b1;
    produce_cur = (row_cur >= emb3_pkg::RowW'(2)) && (col_cur >= emb3_pkg::ColW'(2)) &&
                  ({1'b0, col_cur} < width_eff);
    if (col_inc >= width_eff) begin
      col_count_next = '0;
      if (row_inc >= {1'b0, height_eff}) row_count_next = '0;
      else row_count_next = row_inc[emb3_pkg::RowW-1:0];
    end else begin
      col_count_next = col_inc[emb3_pkg::ColW-1:0];
      row_count_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // line store: {row two back, row one back} per column
  assign wdata = {rdata[emb3_pkg::PixW-1:0], s1_pixel};

  always_ff @(posedge clk) begin
    if (s1_adv) line_mem[s1_addr] <= wdata;
    if (accept) begin
      if (s1_adv && (s1_addr == col_cur[emb3_pkg::AddrW-1:0])) rdata <= wdata;
      else rdata <= line_mem[col_cur[emb3_pkg::AddrW-1:0]];
    end
  end

  // input stage
  assign s1_adv   = s1_valid && (!s1_produce || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_produce <= produce_cur;
      s1_pixel   <= in_data.pixel_in;
      s1_addr    <= col_cur[emb3_pkg::AddrW-1:0];
      s1_row     <= row_cur - emb3_pkg::RowW'(1);
      s1_col     <= col_cur - emb3_pkg::ColW'(1);
    end
  end

  // window and kernel
  assign top_px = rdata[2*emb3_pkg::PixW-1:emb3_pkg::PixW];
  assign mid_px = rdata[emb3_pkg::PixW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        w_top[i] <= '0;
        w_mid[i] <= '0;
        w_bot[i] <= '0;
      end
    end else if (s1_adv) begin
      w_top[0] <= w_top[1];
      w_top[1] <= w_top[2];
      w_top[2] <= top_px;
      w_mid[0] <= w_mid[1];
      w_mid[1] <= w_mid[2];
      w_mid[2] <= mid_px;
      w_bot[0] <= w_bot[1];
      w_bot[1] <= w_bot[2];
      w_bot[2] <= s1_pixel;
    end
  end

  always_comb begin
    pos_sum = emb3_pkg::SumW'(mid_px) + emb3_pkg::SumW'(w_bot[2]) +
              emb3_pkg::SumW'(s1_pixel) + emb3_pkg::SUM_OFFSET;
    neg_sum = emb3_pkg::SumW'(w_top[1]) + emb3_pkg::SumW'(w_top[2]) +
              emb3_pkg::SumW'(w_mid[1]);
    sum     = pos_sum - neg_sum;
    prod    = {1'b0, emb3_pkg::ProdW'(sum) * emb3_pkg::ProdW'(scale_q15)} +
              emb3_pkg::ROUND_HALF;
    scaled  = prod[emb3_pkg::ProdW:emb3_pkg::FracBits];
    if (scaled > (emb3_pkg::ProdW - emb3_pkg::FracBits + 1)'(255)) sat_px = '1;
    else sat_px = scaled[emb3_pkg::PixW-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_produce) begin
      out_data.pixel_out <= sat_px;
      out_data.out_row   <= s1_row;
      out_data.out_col   <= s1_col;
    end
  end

  a_ready_only_blocked_by_stage : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && s1_produce && out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(s1_adv && s1_produce))
    else $error("pending result overwritten");

  a_accept_fills_stage : assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat lost");

  a_result_from_stage : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_produce))
    else $error("result without a source beat");

endmodule
